// ===== hw/rtl/hpid_pkg.sv =====
// ----------------------------------------------------------------------------
// hpid_pkg: shared types and constants for the heading PID unit
// Control word layout, sequencer status, register indexes and the sample
// period used by the integral and derivative terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpid_pkg;

  // Sample period in controller ticks
  localparam int SAMPLE_PERIOD = 1;
  localparam logic [15:0] SamplePeriod16 = 16'(SAMPLE_PERIOD);
  localparam logic signed [33:0] SamplePeriodS = 34'(SAMPLE_PERIOD);

  // Program step counter width
  localparam int StepW = 3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_PROP_CAP   = 3'd3,
    REG_HALF_TURN  = 3'd4,
    REG_FULL_TURN  = 3'd5,
    REG_DRIVE_MIN  = 3'd6,
    REG_DRIVE_MAX  = 3'd7
  } hpid_reg_e;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_P,
    MUL_I,
    MUL_D
  } hpid_mul_e;

  // Accumulator operation
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_OFFS,
    ACC_P,
    ACC_I,
    ACC_D
  } hpid_acc_e;

  // Error register operation
  typedef enum logic [1:0] {
    ERR_HOLD,
    ERR_LOAD,
    ERR_WRAP
  } hpid_err_e;

  // Condition that holds the step counter in place
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hpid_hold_e;

  // One microcode word
  typedef struct packed {
    hpid_hold_e         hold;
    hpid_err_e          err_op;
    hpid_mul_e          mul_sel;
    hpid_acc_e          acc_op;
    logic               out_load;
    logic               jump;
    logic [StepW-1:0]   target;
  } hpid_ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } hpid_status_t;

  // Sequencer output: current word and whether the step executes
  typedef struct packed {
    hpid_ctrl_t ctrl;
    logic       go;
  } hpid_step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/heading_pid_with_angle_wrap_unit.sv =====
// Heading PID controller with angle wrap. Each input beat carries a target
// heading, a measured heading and a feed-forward offset; one output beat
// returns the drive value, clamped to drive_min then drive_max. A microcoded
// sequencer steps one shared 17x17 multiplier through the P, I and D terms,
// so a sample occupies the unit from acceptance until the last step registers
// the result (input ready again the cycle after), plus any output stall while
// a previous result is still waiting. The user must write configuration through
// the plain write port only while the unit is idle; it is not enforced.
// ----------------------------------------------------------------------------
// heading_pid_with_angle_wrap_unit: top level
// Configuration registers, datapath and output register around the
// microcode sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heading_pid_with_angle_wrap_unit (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire        [2:0]  cfg_idx_i,
  input  wire        [15:0] cfg_wdata_i,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire signed [15:0] target_heading_i,
  input  wire signed [15:0] measured_heading_i,
  input  wire signed [15:0] drive_offset_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic signed [15:0] drive_out_o
);

  // Configuration registers
  logic        [14:0] prop_gain_q, integ_gain_q, deriv_gain_q, full_turn_q;
  logic        [13:0] half_turn_q;
  logic signed [15:0] prop_cap_q, drive_min_q, drive_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= 15'd1;
      integ_gain_q <= 15'd0;
      deriv_gain_q <= 15'd0;
      prop_cap_q   <= 16'sd32767;
      half_turn_q  <= 14'd180;
      full_turn_q  <= 15'd360;
      drive_min_q  <= 16'sd0;
      drive_max_q  <= 16'sd100;
    end else if (cfg_we_i) begin
      case (hpid_pkg::hpid_reg_e'(cfg_idx_i))
        hpid_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_wdata_i[14:0];
        hpid_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg_wdata_i[14:0];
        hpid_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_wdata_i[14:0];
        hpid_pkg::REG_PROP_CAP:   prop_cap_q   <= $signed(cfg_wdata_i);
        hpid_pkg::REG_HALF_TURN:  half_turn_q  <= cfg_wdata_i[13:0];
        hpid_pkg::REG_FULL_TURN:  full_turn_q  <= cfg_wdata_i[14:0];
        hpid_pkg::REG_DRIVE_MIN:  drive_min_q  <= $signed(cfg_wdata_i);
        hpid_pkg::REG_DRIVE_MAX:  drive_max_q  <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Sequencer
  hpid_pkg::hpid_status_t status;
  hpid_pkg::hpid_step_t   step;
  hpid_pkg::hpid_ctrl_t   ctrl;
  logic                   go;
  logic                   out_valid_q, out_valid_d;

  assign status.in_valid = in_valid_i;
  assign status.out_busy = out_valid_q && out_stall_i;

  hpid_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .step_o  (step)
  );

  assign ctrl       = step.ctrl;
  assign go         = step.go;
  assign in_stall_o = (ctrl.hold != hpid_pkg::HOLD_IN);

  // Datapath registers
  logic signed [15:0] err_q, err_d;
  logic signed [16:0] diff_q, diff_d;
  logic signed [15:0] offs_q, offs_d;
  logic signed [15:0] last_q, last_d;
  logic signed [15:0] integ_q, integ_d;
  logic signed [15:0] acc_q, acc_d;
  logic signed [33:0] prod_q, prod_d;
  logic signed [15:0] drive_q, drive_d;

  // Error wrap
  logic signed [16:0] err_x, half_x, full_x;
  assign err_x  = {err_q[15], err_q};
  assign half_x = $signed({3'b000, half_turn_q});
  assign full_x = $signed({2'b00, full_turn_q});

  // Shared multiplier
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  always_comb begin
    case (ctrl.mul_sel)
      hpid_pkg::MUL_P: begin
        mul_a = $signed({2'b00, prop_gain_q});
        mul_b = err_x;
      end
      hpid_pkg::MUL_I: begin
        mul_a = $signed({2'b00, integ_gain_q});
        mul_b = err_x;
      end
      hpid_pkg::MUL_D: begin
        mul_a = $signed({2'b00, deriv_gain_q});
        mul_b = diff_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Term shaping from the registered product
  logic signed [15:0] p_raw, p_cap, i_step, d_term;
  logic        [31:0] i_full;
  logic signed [33:0] d_full;
  assign p_raw  = prod_q[15:0];
  assign p_cap  = (p_raw > prop_cap_q) ? prop_cap_q : p_raw;
  assign i_full = prod_q[15:0] * hpid_pkg::SamplePeriod16;
  assign i_step = i_full[15:0];
  assign d_full = prod_q / hpid_pkg::SamplePeriodS;
  assign d_term = d_full[15:0];

  // Clamp lower then upper
  logic signed [15:0] lo_clamped;
  assign lo_clamped = (acc_q < drive_min_q) ? drive_min_q : acc_q;

  // Next-state datapath
  always_comb begin
    err_d       = err_q;
    diff_d      = diff_q;
    offs_d      = offs_q;
    last_d      = last_q;
    integ_d     = integ_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    drive_d     = drive_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (go) begin
      case (ctrl.err_op)
        hpid_pkg::ERR_LOAD: begin
          err_d  = 16'(target_heading_i - measured_heading_i);
          diff_d = {last_q[15], last_q} - {measured_heading_i[15], measured_heading_i};
          offs_d = drive_offset_i;
          last_d = measured_heading_i;
        end
        hpid_pkg::ERR_WRAP: begin
          if (err_x < -half_x) begin
            err_d = 16'(err_x + full_x);
          end else if (err_x > half_x) begin
            err_d = 16'(err_x - full_x);
          end
        end
        default: ;
      endcase
      if (ctrl.mul_sel != hpid_pkg::MUL_NONE) begin
        prod_d = prod;
      end
      case (ctrl.acc_op)
        hpid_pkg::ACC_OFFS: acc_d = offs_q;
        hpid_pkg::ACC_P:    acc_d = acc_q + p_cap;
        hpid_pkg::ACC_I: begin
          integ_d = integ_q + i_step;
          acc_d   = acc_q + integ_q + i_step;
        end
        hpid_pkg::ACC_D:    acc_d = acc_q + d_term;
        default: ;
      endcase
      if (ctrl.out_load) begin
        drive_d     = (lo_clamped > drive_max_q) ? drive_max_q : lo_clamped;
        out_valid_d = 1'b1;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      integ_q     <= integ_d;
      last_q      <= last_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    diff_q  <= diff_d;
    offs_q  <= offs_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    drive_q <= drive_d;
  end

  assign out_valid_o = out_valid_q;
  assign drive_out_o = drive_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hpid_seq.sv =====
// ----------------------------------------------------------------------------
// hpid_seq: microcode sequencer
// Step counter and program table; holds on wait conditions, jumps back to
// the start after the result step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpid_seq (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire hpid_pkg::hpid_status_t status_i,
  output hpid_pkg::hpid_step_t   step_o
);

  logic [hpid_pkg::StepW-1:0] pc_q, pc_d;
  hpid_pkg::hpid_ctrl_t       word;
  logic                       go;

  // Program table
  function automatic hpid_pkg::hpid_ctrl_t rom(input logic [hpid_pkg::StepW-1:0] pc);
    hpid_pkg::hpid_ctrl_t w;
    w = '{hold: hpid_pkg::HOLD_NONE, err_op: hpid_pkg::ERR_HOLD,
          mul_sel: hpid_pkg::MUL_NONE, acc_op: hpid_pkg::ACC_HOLD,
          out_load: 1'b0, jump: 1'b0, target: '0};
    case (pc)
      3'd0: begin  // wait for a sample, latch it
        w.hold   = hpid_pkg::HOLD_IN;
        w.err_op = hpid_pkg::ERR_LOAD;
      end
      3'd1: begin  // wrap error the short way, seed with offset
        w.err_op = hpid_pkg::ERR_WRAP;
        w.acc_op = hpid_pkg::ACC_OFFS;
      end
      3'd2: begin
        w.mul_sel = hpid_pkg::MUL_P;
      end
      3'd3: begin
        w.mul_sel = hpid_pkg::MUL_I;
        w.acc_op  = hpid_pkg::ACC_P;
      end
      3'd4: begin
        w.mul_sel = hpid_pkg::MUL_D;
        w.acc_op  = hpid_pkg::ACC_I;
      end
      3'd5: begin
        w.acc_op = hpid_pkg::ACC_D;
      end
      3'd6: begin  // clamp into output register, restart
        w.hold     = hpid_pkg::HOLD_OUT;
        w.out_load = 1'b1;
        w.jump     = 1'b1;
      end
      default: begin
        w.jump = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Decode current step and hold conditions
  always_comb begin
    word = rom(pc_q);
    case (word.hold)
      hpid_pkg::HOLD_IN:  go = status_i.in_valid;
      hpid_pkg::HOLD_OUT: go = !status_i.out_busy;
      default:            go = 1'b1;
    endcase
    if (!go) begin
      pc_d = pc_q;
    end else if (word.jump) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign step_o.ctrl = word;
  assign step_o.go   = go;

endmodule

`default_nettype wire

// ===== hw/rtl/hpid_checker.sv =====
// ----------------------------------------------------------------------------
// hpid_checker: port-level checks for the heading PID unit
// Watches the handshakes and the sequencing visible at the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpid_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [15:0] drive_out_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_out_o))
    else $error("stalled result beat changed or dropped");

  // Input stays stalled while the wrap, P and I steps run after a sample is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input taken again while a sample is in work");

  // No result appears right after a sample is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o ##1 !out_valid_o)
    else $error("result appeared before the program could finish");

endmodule

bind heading_pid_with_angle_wrap_unit hpid_checker u_hpid_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .drive_out_o(drive_out_o)
);

`default_nettype wire
